[sv/i2cm_pkg.sv]
// i2cm_pkg: shared types and constants of the i2c master bit sequencer
// no dependencies; used by every other file of the block
package i2cm_pkg;

  localparam int DATA_BITS = 8;
  localparam int BYTE_W    = 8;
  localparam int BIT_W     = $clog2(DATA_BITS + 1);

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_READ    = 3'd2,
    CMD_START   = 3'd3,
    CMD_RESTART = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_t;

  typedef enum logic [5:0] {
    OP_IDLE    = 6'b000001,
    OP_WRITE   = 6'b000010,
    OP_READ    = 6'b000100,
    OP_START   = 6'b001000,
    OP_RESTART = 6'b010000,
    OP_STOP    = 6'b100000
  } op_t;

  typedef struct packed {
    logic              scl_drive;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_bit;
    logic              bad_command;
  } res_t;

endpackage

[sv/i2cm_req_if.sv]
// i2cm_req_if: request channel of the i2c master bit sequencer
// depends on i2cm_pkg for the byte width
interface i2cm_req_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                command;
  logic [i2cm_pkg::BYTE_W-1:0] data_byte;
  logic                      sda_line;

  modport source (output valid, command, data_byte, sda_line, input ready);
  modport sink (input valid, command, data_byte, sda_line, output ready);
endinterface

[sv/i2cm_res_if.sv]
// i2cm_res_if: result channel of the i2c master bit sequencer
// depends on i2cm_pkg for the byte width
interface i2cm_res_if;
  logic                      valid;
  logic                      ready;
  logic                      scl_drive;
  logic                      sda_drive;
  logic                      busy_res;
  logic                      done_res;
  logic [i2cm_pkg::BYTE_W-1:0] rx_byte;
  logic                      ack_bit;
  logic                      bad_command;

  modport source (output valid, scl_drive, sda_drive, busy_res, done_res, rx_byte, ack_bit,
                  bad_command, input ready);
  modport sink (input valid, scl_drive, sda_drive, busy_res, done_res, rx_byte, ack_bit,
                bad_command, output ready);
endinterface

[sv/i2cm_seq.sv]
// i2cm_seq: phase sequencer state and next-state logic of the i2c master
// depends on i2cm_pkg; steps once per accepted request and hands back the result
module i2cm_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        acc,
  input  logic [2:0]                  command,
  input  logic [i2cm_pkg::BYTE_W-1:0] data_byte,
  input  logic                        sda_line,
  output i2cm_pkg::res_t              res_next
);

  i2cm_pkg::op_t                     op, op_next;
  logic [1:0]                        sub_cnt, sub_cnt_next;
  logic [i2cm_pkg::BIT_W-1:0]        bit_cnt, bit_cnt_next;
  logic [i2cm_pkg::DATA_BITS-1:0]    tx_shift, tx_shift_next;
  logic [i2cm_pkg::BYTE_W-1:0]       rx_shift, rx_shift_next;
  logic                              scl_level, scl_level_next;
  logic                              sda_level, sda_level_next;
  logic                              ack_held, ack_held_next;
  logic                              is_cmd, is_byte, ack_slot, last_phase;
  logic                              done, bad;

  always_comb begin
    op_next        = op;
    sub_cnt_next   = sub_cnt;
    bit_cnt_next   = bit_cnt;
    tx_shift_next  = tx_shift;
    rx_shift_next  = rx_shift;
    scl_level_next = scl_level;
    sda_level_next = sda_level;
    ack_held_next  = ack_held;
    done           = 1'b0;
    bad            = 1'b0;
    last_phase     = 1'b0;
    is_cmd  = (command == i2cm_pkg::CMD_WRITE) || (command == i2cm_pkg::CMD_READ) ||
              (command == i2cm_pkg::CMD_START) || (command == i2cm_pkg::CMD_RESTART) ||
              (command == i2cm_pkg::CMD_STOP);
    is_byte  = (op == i2cm_pkg::OP_WRITE) || (op == i2cm_pkg::OP_READ);
    ack_slot = (bit_cnt == i2cm_pkg::BIT_W'(i2cm_pkg::DATA_BITS));

    if (is_cmd) begin
      if (op != i2cm_pkg::OP_IDLE) begin
        bad = 1'b1;
      end else begin
        sub_cnt_next = 2'd0;
        bit_cnt_next = '0;
        unique case (command)
          i2cm_pkg::CMD_WRITE: begin
            op_next       = i2cm_pkg::OP_WRITE;
            tx_shift_next = i2cm_pkg::DATA_BITS'(data_byte);
          end
          i2cm_pkg::CMD_READ: begin
            op_next       = i2cm_pkg::OP_READ;
            rx_shift_next = '0;
          end
          i2cm_pkg::CMD_START:   op_next = i2cm_pkg::OP_START;
          i2cm_pkg::CMD_RESTART: op_next = i2cm_pkg::OP_RESTART;
          default:               op_next = i2cm_pkg::OP_STOP;
        endcase
      end
    end else if (op != i2cm_pkg::OP_IDLE) begin
      if (is_byte) begin
        unique case (sub_cnt)
          2'd0: begin
            // write bits come off the top of the shifter; read bits and ack clock release sda
            if (op == i2cm_pkg::OP_WRITE && !ack_slot) begin
              sda_level_next = tx_shift[i2cm_pkg::DATA_BITS-1];
              tx_shift_next  = tx_shift << 1;
            end else begin
              sda_level_next = 1'b1;
            end
          end
          2'd1: scl_level_next = 1'b1;
          2'd2: begin
            if (ack_slot) begin
              ack_held_next = sda_line;
            end else if (op == i2cm_pkg::OP_READ) begin
              rx_shift_next = {rx_shift[i2cm_pkg::BYTE_W-2:0], sda_line};
            end
            scl_level_next = 1'b0;
          end
          default: ;
        endcase
        last_phase = (sub_cnt == 2'd2) && ack_slot;
      end else if (op == i2cm_pkg::OP_START) begin
        unique case (sub_cnt)
          2'd0: begin
            sda_level_next = 1'b1;
            scl_level_next = 1'b1;
          end
          2'd1:    sda_level_next = 1'b0;
          default: scl_level_next = 1'b0;
        endcase
        last_phase = (sub_cnt == 2'd2);
      end else if (op == i2cm_pkg::OP_STOP) begin
        unique case (sub_cnt)
          2'd0:    sda_level_next = 1'b0;
          2'd1:    scl_level_next = 1'b1;
          default: sda_level_next = 1'b1;
        endcase
        last_phase = (sub_cnt == 2'd2);
      end else begin
        // stop then start: phases three and four sit in the second bit slot
        if (bit_cnt == i2cm_pkg::BIT_W'(1)) begin
          unique case (sub_cnt)
            2'd0:    sda_level_next = 1'b0;
            default: scl_level_next = 1'b0;
          endcase
        end else begin
          unique case (sub_cnt)
            2'd0:    sda_level_next = 1'b0;
            2'd1:    scl_level_next = 1'b1;
            default: sda_level_next = 1'b1;
          endcase
        end
        last_phase = (bit_cnt == i2cm_pkg::BIT_W'(1)) && (sub_cnt == 2'd1);
      end

      if (last_phase) begin
        op_next      = i2cm_pkg::OP_IDLE;
        sub_cnt_next = 2'd0;
        bit_cnt_next = '0;
        done         = 1'b1;
      end else if (sub_cnt == 2'd2) begin
        sub_cnt_next = 2'd0;
        bit_cnt_next = bit_cnt + i2cm_pkg::BIT_W'(1);
      end else begin
        sub_cnt_next = sub_cnt + 2'd1;
      end
    end

    res_next.scl_drive   = scl_level_next;
    res_next.sda_drive   = sda_level_next;
    res_next.busy_res    = (op_next != i2cm_pkg::OP_IDLE);
    res_next.done_res    = done;
    res_next.rx_byte     = rx_shift_next;
    res_next.ack_bit     = ack_held_next;
    res_next.bad_command = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op        <= i2cm_pkg::OP_IDLE;
      sub_cnt   <= 2'd0;
      bit_cnt   <= '0;
      tx_shift  <= '0;
      rx_shift  <= '0;
      scl_level <= 1'b1;
      sda_level <= 1'b1;
      ack_held  <= 1'b1;
    end else if (acc) begin
      op        <= op_next;
      sub_cnt   <= sub_cnt_next;
      bit_cnt   <= bit_cnt_next;
      tx_shift  <= tx_shift_next;
      rx_shift  <= rx_shift_next;
      scl_level <= scl_level_next;
      sda_level <= sda_level_next;
      ack_held  <= ack_held_next;
    end
  end

  a_cmd_starts: assert property (@(posedge clk) disable iff (rst)
    acc && is_cmd && op == i2cm_pkg::OP_IDLE |=> op != i2cm_pkg::OP_IDLE)
    else $error("accepted command did not start a sequence");

  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    acc && res_next.done_res |=> op == i2cm_pkg::OP_IDLE)
    else $error("sequence finished but stayed busy");

  a_sub_range: assert property (@(posedge clk) disable iff (rst)
    sub_cnt != 2'd3)
    else $error("phase counter out of range");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_cnt <= i2cm_pkg::BIT_W'(i2cm_pkg::DATA_BITS))
    else $error("bit counter beyond ack slot");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    op == i2cm_pkg::OP_IDLE |-> sub_cnt == 2'd0 && bit_cnt == '0)
    else $error("counters not cleared while idle");

  a_bad_busy: assert property (@(posedge clk) disable iff (rst)
    res_next.bad_command |-> op != i2cm_pkg::OP_IDLE)
    else $error("command flagged while idle");

endmodule

[sv/i2cm_out_reg.sv]
// i2cm_out_reg: result register between the sequencer and the result channel
// depends on i2cm_pkg for the result struct
module i2cm_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  i2cm_pkg::res_t res_in,
  output logic           res_valid,
  input  logic           res_ready,
  output i2cm_pkg::res_t res_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

[sv/i2c_master_bit_sequencer_core.sv]
// i2c_master_bit_sequencer_core: top level of the i2c master bit sequencer
// depends on i2cm_pkg, i2cm_req_if, i2cm_res_if, i2cm_seq and i2cm_out_reg
//
// usage:
//   req carries one request per handshake: a command (tick, write byte, read
//   byte, start, stop then start, stop), the byte to send and the sampled
//   sda level. res returns exactly one result per request: the scl and sda
//   drive levels, busy, done, the gathered byte, the ack level and a flag for
//   a command that arrived while a sequence was running.
//   a command only loads a sequence; every later tick moves one phase. a bit
//   takes three ticks, a byte with its ack clock takes 27 ticks.
// timing and throughput:
//   a request is handled in the cycle it is accepted and its result is
//   registered, showing on res in the next cycle. one request per cycle is
//   accepted, limited only by the single result register: req.ready is high
//   while that register is empty or being drained in the same cycle.
// reset:
//   synchronous rst returns to idle with scl and sda released, counters and
//   shifters cleared, ack held at nak, and no result pending.
// stalls:
//   while res.ready is low a pending result holds and req.ready drops, so the
//   sequencer state does not advance until the result is taken.
module i2c_master_bit_sequencer_core (
  input logic     clk,
  input logic     rst,
  i2cm_req_if.sink   req,
  i2cm_res_if.source res
);

  logic           acc;
  logic           res_valid;
  i2cm_pkg::res_t res_next;
  i2cm_pkg::res_t res_q;

  assign req.ready = !res_valid || res.ready;
  assign acc       = req.valid && req.ready;

  i2cm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .command   (req.command),
    .data_byte (req.data_byte),
    .sda_line  (req.sda_line),
    .res_next  (res_next)
  );

  i2cm_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (acc),
    .res_in    (res_next),
    .res_valid (res_valid),
    .res_ready (res.ready),
    .res_q     (res_q)
  );

  assign res.valid       = res_valid;
  assign res.scl_drive   = res_q.scl_drive;
  assign res.sda_drive   = res_q.sda_drive;
  assign res.busy_res    = res_q.busy_res;
  assign res.done_res    = res_q.done_res;
  assign res.rx_byte     = res_q.rx_byte;
  assign res.ack_bit     = res_q.ack_bit;
  assign res.bad_command = res_q.bad_command;

endmodule

[tb/i2cm_bus_checker.sv]
// i2cm_bus_checker: watches the request and result channels of the i2c master
// bit sequencer, predicts every result and compares it field by field
// depends on i2cm_pkg, i2cm_req_if and i2cm_res_if
module i2cm_bus_checker
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  i2cm_req_if        req,
  i2cm_res_if        res,
  output int         fail_count,
  output int         pending,
  output int         checked,
  output int         done_count,
  output int         refused_count
);

  // predicted bus state; CMD_TICK in bus_op means no sequence is running
  cmd_t              bus_op;
  int                phase_q;
  logic [BYTE_W-1:0] tx_q;
  logic [BYTE_W-1:0] rx_q;
  logic              scl_q;
  logic              sda_q;
  logic              ack_q;

  res_t              bus_results_q[$];

  function automatic res_t step_bus(logic [2:0] cmd, logic [BYTE_W-1:0] data, logic line);
    res_t r;
    logic fin;
    logic refused;
    int   p;
    int   bit_n;
    int   sub;
    int   idx;
    int   seq_len;
    fin     = 1'b0;
    refused = 1'b0;
    if (cmd >= CMD_WRITE && cmd <= CMD_STOP) begin
      if (bus_op != CMD_TICK) begin
        refused = 1'b1;
      end else begin
        bus_op  = cmd_t'(cmd);
        phase_q = 0;
        if (cmd == CMD_WRITE) tx_q = data;
        if (cmd == CMD_READ) rx_q = '0;
      end
    end else if (bus_op != CMD_TICK) begin
      // codes six and seven land here too and act as a tick
      p = phase_q;
      if (bus_op == CMD_WRITE || bus_op == CMD_READ) begin
        bit_n = p / 3;
        sub   = p % 3;
        case (sub)
          0: begin
            if (bus_op == CMD_WRITE && bit_n < DATA_BITS) begin
              idx   = DATA_BITS - 1 - bit_n;
              sda_q = (idx < BYTE_W) ? tx_q[idx] : 1'b0;
            end else begin
              sda_q = 1'b1;
            end
          end
          1: scl_q = 1'b1;
          default: begin
            if (bit_n >= DATA_BITS) ack_q = line;
            else if (bus_op == CMD_READ) rx_q = {rx_q[BYTE_W-2:0], line};
            scl_q = 1'b0;
          end
        endcase
      end else if (bus_op == CMD_START) begin
        case (p)
          0: begin
            sda_q = 1'b1;
            scl_q = 1'b1;
          end
          1: sda_q = 1'b0;
          default: scl_q = 1'b0;
        endcase
      end else if (bus_op == CMD_STOP) begin
        case (p)
          0: sda_q = 1'b0;
          1: scl_q = 1'b1;
          default: sda_q = 1'b1;
        endcase
      end else begin
        // stop then start
        case (p)
          0: sda_q = 1'b0;
          1: scl_q = 1'b1;
          2: sda_q = 1'b1;
          3: sda_q = 1'b0;
          default: scl_q = 1'b0;
        endcase
      end
      phase_q = p + 1;
      case (bus_op)
        CMD_WRITE, CMD_READ: seq_len = 3 * (DATA_BITS + 1);
        CMD_RESTART: seq_len = 5;
        default: seq_len = 3;
      endcase
      if (phase_q >= seq_len) begin
        bus_op  = CMD_TICK;
        phase_q = 0;
        fin     = 1'b1;
      end
    end
    r.scl_drive   = scl_q;
    r.sda_drive   = sda_q;
    r.busy_res    = (bus_op != CMD_TICK);
    r.done_res    = fin;
    r.rx_byte     = rx_q;
    r.ack_bit     = ack_q;
    r.bad_command = refused;
    return r;
  endfunction

  task automatic cmp_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      bus_op        = CMD_TICK;
      phase_q       = 0;
      tx_q          = '0;
      rx_q          = '0;
      scl_q         = 1'b1;
      sda_q         = 1'b1;
      ack_q         = 1'b1;
      fail_count    = 0;
      checked       = 0;
      done_count    = 0;
      refused_count = 0;
      bus_results_q.delete();
    end else begin
      // results always trail their request, so take the result side first
      if (res.valid && res.ready) begin
        if (bus_results_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = bus_results_q.pop_front();
          cmp_field("scl_drive", int'(want.scl_drive), int'(res.scl_drive));
          cmp_field("sda_drive", int'(want.sda_drive), int'(res.sda_drive));
          cmp_field("busy_res", int'(want.busy_res), int'(res.busy_res));
          cmp_field("done_res", int'(want.done_res), int'(res.done_res));
          cmp_field("rx_byte", int'(want.rx_byte), int'(res.rx_byte));
          cmp_field("ack_bit", int'(want.ack_bit), int'(res.ack_bit));
          cmp_field("bad_command", int'(want.bad_command), int'(res.bad_command));
          checked++;
          if (want.done_res) done_count++;
          if (want.bad_command) refused_count++;
        end
      end
      if (req.valid && req.ready)
        bus_results_q.push_back(step_bus(req.command, req.data_byte, req.sda_line));
    end
    pending <= bus_results_q.size();
  end

endmodule

[tb/i2c_master_bit_sequencer_core_test.sv]
// i2c_master_bit_sequencer_core_test: stimulus and verdict for the i2c master
// bit sequencer; drives well-formed sequences with noise and random stalls
// depends on i2cm_pkg, both channel interfaces, i2cm_bus_checker and the core
module i2c_master_bit_sequencer_core_test;
  import i2cm_pkg::*;

  localparam int ITEM_GOAL = 1250;
  localparam int CALM_FROM = 1100;

  logic clk;
  logic rst;
  int   sent;
  bit   calm;
  int   fail_count;
  int   pending;
  int   checked;
  int   done_count;
  int   refused_count;

  i2cm_req_if req ();
  i2cm_res_if res ();

  i2c_master_bit_sequencer_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  i2cm_bus_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .res           (res),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .done_count    (done_count),
    .refused_count (refused_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("i2c_master_bit_sequencer_core_test failed");
    $finish;
  end

  // result side back-pressure
  initial begin
    res.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic send_req(logic [2:0] cmd, logic [BYTE_W-1:0] data, logic line);
    if (!calm && $urandom_range(0, 9) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.command   <= cmd;
    req.data_byte <= data;
    req.sda_line  <= line;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
    if (sent >= CALM_FROM) calm = 1'b1;
  endtask

  // one command followed by its ticks; now and then a refused command or an
  // unused code (which still advances) lands in the middle
  task automatic run_seq(cmd_t op, logic [BYTE_W-1:0] data, int noise_pct);
    int left;
    int r;
    case (op)
      CMD_WRITE, CMD_READ: left = 3 * (DATA_BITS + 1);
      CMD_RESTART: left = 5;
      default: left = 3;
    endcase
    send_req(op, data, 1'($urandom_range(0, 1)));
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < noise_pct) begin
        send_req(3'($urandom_range(CMD_WRITE, CMD_STOP)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
      end else if (r < 2 * noise_pct) begin
        send_req(3'($urandom_range(6, 7)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        left--;
      end else begin
        send_req(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        left--;
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] data;
    int r;
    sent          = 0;
    calm          = 1'b0;
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.command   <= CMD_TICK;
    req.data_byte <= '0;
    req.sda_line  <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // idle ticks and unused codes change nothing
    send_req(CMD_TICK, 8'hff, 1'b1);
    send_req(3'd6, 8'h00, 1'b0);
    send_req(3'd7, 8'hff, 1'b1);
    // start, with a write refused halfway
    send_req(CMD_START, 8'h00, 1'b0);
    send_req(CMD_TICK, 8'h00, 1'b0);
    send_req(CMD_WRITE, 8'ha5, 1'b1);
    send_req(CMD_TICK, 8'h00, 1'b0);
    send_req(CMD_TICK, 8'h00, 1'b1);
    run_seq(CMD_RESTART, 8'h00, 0);
    run_seq(CMD_STOP, 8'hff, 0);

    while (sent < ITEM_GOAL) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: data = 8'h00;
        1: data = 8'hff;
        default: data = 8'($urandom_range(0, 255));
      endcase
      if (r < 85) begin
        run_seq(cmd_t'($urandom_range(CMD_WRITE, CMD_STOP)), data, (r < 60) ? 0 : 4);
      end else if (r < 95) begin
        send_req(($urandom_range(0, 1) != 0) ? 3'($urandom_range(6, 7)) : CMD_TICK, data,
                 1'($urandom_range(0, 1)));
      end else begin
        // broken sequence: a stray command partway through a read or write
        run_seq(($urandom_range(0, 1) != 0) ? CMD_READ : CMD_WRITE, data, 15);
      end
    end

    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests sent, %0d results checked", sent, checked);
    $display("%0d sequences completed, %0d commands refused while busy",
             done_count, refused_count);
    if (fail_count == 0) begin
      $display("i2c_master_bit_sequencer_core_test passed");
    end else begin
      $display("i2c_master_bit_sequencer_core_test failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/i2cm_pkg.sv
sv/i2cm_req_if.sv
sv/i2cm_res_if.sv
sv/i2cm_seq.sv
sv/i2cm_out_reg.sv
sv/i2c_master_bit_sequencer_core.sv
tb/i2cm_bus_checker.sv
tb/i2c_master_bit_sequencer_core_test.sv
